FILE: rtl/ttcs_pkg.sv
// ----------------------------------------------------------------------------
// ttcs_pkg
// Shared types and constants of the text terminal engine.
// ----------------------------------------------------------------------------
package ttcs_pkg;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } ttcs_cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_REJECT = 2'd1,
    STATUS_RANGE  = 2'd2
  } ttcs_status_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_FILL,
    ST_DONE
  } ttcs_state_e;

  // Configuration register indexes.
  localparam logic REG_FG = 1'b0;
  localparam logic REG_BG = 1'b1;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'd32;
  localparam logic [7:0] LOWEST_CODE  = 8'd20;
  localparam logic [7:0] HIGHEST_CODE = 8'd126;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  char_code;
    logic [10:0] cell_address;
  } ttcs_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] cell_value;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
  } ttcs_out_t;

endpackage

FILE: rtl/ttcs_ram.sv
// ----------------------------------------------------------------------------
// ttcs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ttcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: rtl/ttcs_outreg.sv
// ----------------------------------------------------------------------------
// ttcs_outreg
// One-word output register between the sequencer and the result channel.
// ----------------------------------------------------------------------------
module ttcs_outreg
  import ttcs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  input  ttcs_out_t push_data_i,
  output logic      push_ready_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ttcs_out_t out_data_o
);

  logic      valid_q, valid_d;
  ttcs_out_t data_q;

  // The slot is free when empty or when its word leaves at this edge.
  assign push_ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (push_valid_i && push_ready_o) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_valid_i && push_ready_o) begin
      data_q <= push_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

FILE: rtl/ttcs_ctrl.sv
// ----------------------------------------------------------------------------
// ttcs_ctrl
// Command sequencer: cursor, cell writes, row copy for scrolling, blank fill
// and the clearing pass after reset, all through the cell RAM ports.
// ----------------------------------------------------------------------------
module ttcs_ctrl
  import ttcs_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  ttcs_in_t                             in_data_i,
  input  logic [7:0]                           attr_i,
  output logic                                 ram_we_o,
  output logic [$clog2(ROWS*COLUMNS)-1:0]      ram_waddr_o,
  output logic [15:0]                          ram_wdata_o,
  output logic                                 ram_re_o,
  output logic [$clog2(ROWS*COLUMNS)-1:0]      ram_raddr_o,
  input  logic [15:0]                          ram_rdata_i,
  output logic                                 push_valid_o,
  output ttcs_out_t                            push_data_o,
  input  logic                                 push_ready_i
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int MOVE_COUNT = CELL_COUNT - COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int COL_W      = $clog2(COLUMNS);

  ttcs_state_e       state_q, state_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic              pend_q, pend_d;
  logic [ADDR_W-1:0] pend_addr_q, pend_addr_d;
  logic [1:0]        status_q, status_d;
  logic [15:0]       value_q, value_d;

  logic              accept;
  logic              is_newline;
  logic              is_print;
  logic              at_row_end;
  logic              at_last_row;
  logic              line_feed;
  logic              addr_ok;
  logic [ADDR_W-1:0] cur_addr;

  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign is_newline  = (in_data_i.char_code == NEWLINE_CODE);
  assign is_print    = (in_data_i.char_code >= LOWEST_CODE) &&
                       (in_data_i.char_code <= HIGHEST_CODE);
  assign at_row_end  = (col_q == COL_W'(COLUMNS - 1));
  assign at_last_row = (row_q == ROW_W'(ROWS - 1));
  // A put moves to the next line on newline or when it fills the row.
  assign line_feed   = is_newline || (is_print && at_row_end);
  assign addr_ok     = (32'(in_data_i.cell_address) < 32'(CELL_COUNT));
  assign cur_addr    = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (idx_q == ADDR_W'(CELL_COUNT - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (ttcs_cmd_e'(in_data_i.cmd))
            CMD_PUT: begin
              state_d = (line_feed && at_last_row) ? ST_SCROLL : ST_DONE;
            end
            CMD_CLEAR: state_d = ST_FILL;
            CMD_READ:  state_d = addr_ok ? ST_READ : ST_DONE;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_READ: state_d = ST_DONE;
      ST_SCROLL: begin
        if (idx_q == ADDR_W'(MOVE_COUNT)) state_d = ST_FILL;
      end
      ST_FILL: begin
        if (idx_q == ADDR_W'(CELL_COUNT - 1)) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (push_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and RAM controls.
  always_comb begin
    row_d       = row_q;
    col_d       = col_q;
    idx_d       = idx_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    status_d    = status_q;
    value_d     = value_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = idx_q;
    ram_wdata_o = {attr_i, SPACE_CODE};
    ram_re_o    = 1'b0;
    ram_raddr_o = idx_q + ADDR_W'(COLUMNS);
    case (state_q)
      ST_INIT: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = '0;
        idx_d       = idx_q + ADDR_W'(1);
      end
      ST_IDLE: begin
        idx_d = '0;
        if (accept) begin
          status_d = STATUS_OK;
          value_d  = '0;
          case (ttcs_cmd_e'(in_data_i.cmd))
            CMD_PUT: begin
              if (!is_newline && !is_print) begin
                status_d = STATUS_REJECT;
              end else begin
                if (is_print) begin
                  ram_we_o    = 1'b1;
                  ram_waddr_o = cur_addr;
                  ram_wdata_o = {attr_i, in_data_i.char_code};
                  col_d       = col_q + COL_W'(1);
                end
                if (line_feed) begin
                  col_d = '0;
                  if (!at_last_row) row_d = row_q + ROW_W'(1);
                end
              end
            end
            CMD_READ: begin
              if (addr_ok) begin
                ram_re_o    = 1'b1;
                ram_raddr_o = ADDR_W'(in_data_i.cell_address);
              end else begin
                status_d = STATUS_RANGE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: value_d = ram_rdata_i;
      ST_SCROLL: begin
        // Read one row ahead and write the word read in the previous cycle.
        if (idx_q != ADDR_W'(MOVE_COUNT)) begin
          ram_re_o    = 1'b1;
          pend_d      = 1'b1;
          pend_addr_d = idx_q;
          idx_d       = idx_q + ADDR_W'(1);
        end
        if (pend_q) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = pend_addr_q;
          ram_wdata_o = ram_rdata_i;
        end
      end
      ST_FILL: begin
        ram_we_o = 1'b1;
        idx_d    = idx_q + ADDR_W'(1);
      end
      default: ;
    endcase
  end

  assign push_valid_o           = (state_q == ST_DONE);
  assign push_data_o.status     = status_q;
  assign push_data_o.cell_value = value_q;
  assign push_data_o.cursor_row = 5'(row_q);
  assign push_data_o.cursor_col = 7'(col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      row_q   <= '0;
      col_q   <= '0;
      idx_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q <= pend_addr_d;
    status_q    <= status_d;
    value_q     <= value_d;
  end

endmodule

FILE: rtl/text_terminal_cursor_scroll_top.sv
// ----------------------------------------------------------------------------
// text_terminal_cursor_scroll_top
// Text-mode terminal engine: a cell RAM of ROWS x COLUMNS character and
// attribute words with a cursor, line wrap, one-line scroll and clear.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                   | word
//  in      | input     | in_valid_i / in_stall_o     | ttcs_in_t  (cmd, char, address)
//  out     | output    | out_valid_o / out_stall_i   | ttcs_out_t (status, cell, cursor)
//  cfg     | input     | cfg_we_i, cfg_index_i       | cfg_data_i (4-bit color)
//
//  A put without scroll, a reject and cmd 3 go straight to the result state;
//  an in-range read passes a RAM read state. A scroll copies the rows up and blanks
//  the last row and a clear blanks all cells, one cell per cycle through
//  the single write port of the cell RAM. After reset a clearing pass
//  zeroes the RAM, with in_stall_o high; configuration writes are taken
//  during it. A result waits in the output register while the next word is accepted.
// ----------------------------------------------------------------------------
module text_terminal_cursor_scroll_top
  import ttcs_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ttcs_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ttcs_out_t out_data_o,
  input  logic      cfg_we_i,
  input  logic      cfg_index_i,
  input  logic [3:0] cfg_data_i
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  logic [3:0]        fg_q;
  logic [3:0]        bg_q;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [15:0]       ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [15:0]       ram_rdata;
  logic              push_valid;
  logic              push_ready;
  ttcs_out_t         push_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= 4'd7;
      bg_q <= 4'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FG:  fg_q <= cfg_data_i;
        REG_BG:  bg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ttcs_ctrl #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .attr_i      ({bg_q, fg_q}),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .push_valid_o(push_valid),
    .push_data_o (push_data),
    .push_ready_i(push_ready)
  );

  ttcs_ram #(
    .WIDTH(16),
    .DEPTH(CELL_COUNT)
  ) u_cell_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  ttcs_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_data_i (push_data),
    .push_ready_o(push_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: rtl/ttcs_checker.sv
// ----------------------------------------------------------------------------
// ttcs_checker
// Port-level checks of the terminal engine, bound to the top level.
// ----------------------------------------------------------------------------
module ttcs_checker
  import ttcs_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input ttcs_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input ttcs_out_t out_data_o
);

  // A word held back on the result side stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // The input is stalled in the cycle after each accepted command.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a command was taken");

  // The cursor never leaves the grid.
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(out_data_o.cursor_col) < COLUMNS) &&
                    (32'(out_data_o.cursor_row) < ROWS))
    else $error("cursor outside the grid");

  // Only a successful read carries cell data; status code 3 is never made.
  a_status_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != STATUS_OK) |->
      (out_data_o.cell_value == '0) && (out_data_o.status != 2'd3))
    else $error("bad status or data on a failed command");

endmodule

bind text_terminal_cursor_scroll_top ttcs_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_ttcs_checker (.*);

FILE: verif/text_terminal_cursor_scroll_top_test.sv
// ----------------------------------------------------------------------------
// text_terminal_cursor_scroll_top_test
// Self-checking bench for the text terminal engine. A short scripted run
// covers reads at the ends of the screen, rejected codes, newline, clear and
// the unused command. Random traffic follows: text lines that wrap and
// scroll, reads near the cursor, clears and noise, under several color
// settings. Each result is checked against a screen model or a scripted value.
// ----------------------------------------------------------------------------
module text_terminal_cursor_scroll_top_test;
  import ttcs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam logic [7:0] RESET_ATTR   = 8'h07;
  localparam int         PHASES       = 4;
  localparam int         PHASE_WORDS  = 100;
  localparam int         LONG_HOLD_AT = 150;
  localparam int         LONG_HOLD    = 300;
  localparam int         LIMIT_CYCLES = 4_000_000;

  typedef struct packed {
    ttcs_in_t  word;
    logic      typed;
    ttcs_out_t want;
  } script_row_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  ttcs_in_t   in_data_i   = '0;
  logic       out_stall_i = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic       cfg_index_i = REG_FG;
  logic [3:0] cfg_data_i  = '0;
  logic       in_stall_o;
  logic       out_valid_o;
  ttcs_out_t  out_data_o;

  // Screen model: cells, cursor and the current colors.
  logic [15:0] screen [CELLS];
  int          cur_row;
  int          cur_col;
  logic [3:0]  fg_sel;
  logic [3:0]  bg_sel;

  ttcs_out_t   pending_results[$];
  script_row_t script[$];
  int          mismatches;
  int          results_seen;
  int          cycle_count;
  int          send_run, recv_run;
  bit          send_calm, recv_calm;

  text_terminal_cursor_scroll_top #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [15:0] paint(input logic [7:0] ch);
    return {bg_sel, fg_sel, ch};
  endfunction

  function automatic void advance_line();
    cur_col = 0;
    if (cur_row == ROWS - 1) begin
      for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = paint(SPACE_CODE);
    end else begin
      cur_row++;
    end
  endfunction

  function automatic ttcs_out_t apply_command(input ttcs_in_t w);
    ttcs_out_t r;
    r = '0;
    case (w.cmd)
      CMD_PUT: begin
        if (w.char_code == NEWLINE_CODE) begin
          advance_line();
        end else if (w.char_code < LOWEST_CODE || w.char_code > HIGHEST_CODE) begin
          r.status = STATUS_REJECT;
        end else begin
          screen[cur_row * COLUMNS + cur_col] = paint(w.char_code);
          cur_col++;
          if (cur_col == COLUMNS) advance_line();
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen[i] = paint(SPACE_CODE);
      end
      CMD_READ: begin
        if (w.cell_address < CELLS) r.cell_value = screen[w.cell_address];
        else r.status = STATUS_RANGE;
      end
      default: ;
    endcase
    r.cursor_row = 5'(cur_row);
    r.cursor_col = 7'(cur_col);
    return r;
  endfunction

  function automatic ttcs_in_t make_word(input logic [1:0] cmd, input logic [7:0] ch,
                                         input logic [10:0] addr);
    ttcs_in_t w;
    w.cmd          = cmd;
    w.char_code    = ch;
    w.cell_address = addr;
    return w;
  endfunction

  function automatic void add_row(input logic [1:0] cmd, input logic [7:0] ch,
                                  input logic [10:0] addr, input logic typed,
                                  input logic [1:0] status, input logic [15:0] value,
                                  input int row, input int col);
    script_row_t s;
    s.word             = make_word(cmd, ch, addr);
    s.typed            = typed;
    s.want.status      = status;
    s.want.cell_value  = value;
    s.want.cursor_row  = 5'(row);
    s.want.cursor_col  = 7'(col);
    script.push_back(s);
  endfunction

  // Waits come in stretches: some stretches are calm, others draw 0 to 14.
  function automatic int draw_wait(inout int run_left, inout bit calm);
    if (run_left == 0) begin
      run_left = $urandom_range(1, 40);
      calm     = ($urandom_range(0, 2) == 0);
    end
    run_left--;
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic void report(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in %s at result %0d: expected %0h, got %0h",
               what, results_seen, want, got);
  endfunction

  function automatic void check_result(input ttcs_out_t got);
    ttcs_out_t want;
    if (pending_results.size() == 0) begin
      report("unexpected word", 0, int'(got));
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status) report("status", want.status, got.status);
    if (got.cell_value !== want.cell_value)
      report("cell_value", want.cell_value, got.cell_value);
    if (got.cursor_row !== want.cursor_row)
      report("cursor_row", want.cursor_row, got.cursor_row);
    if (got.cursor_col !== want.cursor_col)
      report("cursor_col", want.cursor_col, got.cursor_col);
  endfunction

  task automatic send_word(input ttcs_in_t w, input logic typed, input ttcs_out_t want);
    int        gap;
    ttcs_out_t predicted;
    gap = draw_wait(send_run, send_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = apply_command(w);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic write_colors(input logic [3:0] fg, input logic [3:0] bg);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_FG;
    cfg_data_i  <= fg;
    @(posedge clk_i);
    cfg_index_i <= REG_BG;
    cfg_data_i  <= bg;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    fg_sel = fg;
    bg_sel = bg;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Mostly text lines that wrap at the row end and scroll at the bottom,
  // mixed with reads near the cursor, clears and arbitrary words.
  task automatic run_traffic(input int quota);
    int         sent;
    int         kind;
    int         len;
    int         row;
    logic [1:0] cmd;
    sent = 0;
    while (sent < quota) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(70, 90) : $urandom_range(0, 12);
        repeat (len)
          send_word(make_word(CMD_PUT, 8'($urandom_range(LOWEST_CODE, HIGHEST_CODE)),
                              11'($urandom)), 1'b0, '0);
        sent += len;
        if ($urandom_range(0, 3) != 0) begin
          send_word(make_word(CMD_PUT, NEWLINE_CODE, 11'($urandom)), 1'b0, '0);
          sent++;
        end
      end else if (kind < 80) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 4) == 0) begin
            row = $urandom_range(0, 2047);
          end else begin
            row = ($urandom_range(0, 1) == 0) ? cur_row : $urandom_range(0, ROWS - 1);
            row = row * COLUMNS + $urandom_range(0, COLUMNS - 1);
          end
          send_word(make_word(CMD_READ, 8'($urandom), 11'(row)), 1'b0, '0);
          sent++;
        end
      end else if (kind < 84) begin
        send_word(make_word(CMD_CLEAR, 8'($urandom), 11'($urandom)), 1'b0, '0);
        sent++;
      end else begin
        cmd = 2'($urandom_range(0, 3));
        send_word(make_word(cmd, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047))),
                  1'b0, '0);
        if (cmd != CMD_UNUSED) sent++;
      end
    end
  endtask

  initial begin : stimulus
    for (int i = 0; i < CELLS; i++) screen[i] = '0;
    cur_row = 0;
    cur_col = 0;
    fg_sel  = 4'd7;
    bg_sel  = 4'd0;

    add_row(CMD_READ,   8'd0,           11'd0,          1'b1, STATUS_OK,     16'd0, 0, 0);
    add_row(CMD_READ,   8'd0,           11'(CELLS - 1), 1'b1, STATUS_OK,     16'd0, 0, 0);
    add_row(CMD_READ,   8'd0,           11'(CELLS),     1'b1, STATUS_RANGE,  16'd0, 0, 0);
    add_row(CMD_READ,   8'hFF,          11'd2047,       1'b1, STATUS_RANGE,  16'd0, 0, 0);
    add_row(CMD_PUT,    8'd0,           11'd0,          1'b1, STATUS_REJECT, 16'd0, 0, 0);
    add_row(CMD_PUT,    8'(LOWEST_CODE - 1), 11'd0,     1'b1, STATUS_REJECT, 16'd0, 0, 0);
    add_row(CMD_PUT,    8'(HIGHEST_CODE + 1), 11'd0,    1'b1, STATUS_REJECT, 16'd0, 0, 0);
    add_row(CMD_PUT,    8'hFF,          11'd2047,       1'b1, STATUS_REJECT, 16'd0, 0, 0);
    add_row(CMD_PUT,    LOWEST_CODE,    11'd0,          1'b1, STATUS_OK,     16'd0, 0, 1);
    add_row(CMD_PUT,    HIGHEST_CODE,   11'd0,          1'b1, STATUS_OK,     16'd0, 0, 2);
    add_row(CMD_READ,   8'd0,           11'd0,          1'b1, STATUS_OK,
            {RESET_ATTR, LOWEST_CODE}, 0, 2);
    add_row(CMD_READ,   8'd0,           11'd1,          1'b0, STATUS_OK,     16'd0, 0, 0);
    add_row(CMD_PUT,    NEWLINE_CODE,   11'd0,          1'b1, STATUS_OK,     16'd0, 1, 0);
    add_row(CMD_UNUSED, 8'hFF,          11'd2047,       1'b1, STATUS_OK,     16'd0, 1, 0);
    add_row(CMD_CLEAR,  8'd0,           11'd0,          1'b1, STATUS_OK,     16'd0, 1, 0);
    add_row(CMD_READ,   8'd0,           11'd0,          1'b1, STATUS_OK,
            {RESET_ATTR, SPACE_CODE}, 1, 0);
    add_row(CMD_READ,   8'd0,           11'(CELLS - 1), 1'b0, STATUS_OK,     16'd0, 0, 0);
    add_row(CMD_PUT,    8'd65,          11'd0,          1'b0, STATUS_OK,     16'd0, 0, 0);
    add_row(CMD_READ,   8'd0,           11'(COLUMNS),   1'b0, STATUS_OK,     16'd0, 0, 0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_colors(4'd7, 4'd0);

    foreach (script[i]) send_word(script[i].word, script[i].typed, script[i].want);

    for (int p = 0; p < PHASES; p++) begin
      in_valid_i <= 1'b0;
      wait_drained();
      case (p)
        0:       write_colors(4'd15, 4'd15);
        1:       write_colors(4'd0, 4'd0);
        2:       write_colors(4'($urandom), 4'($urandom));
        default: write_colors(4'd0, 4'd15);
      endcase
      run_traffic(PHASE_WORDS);
    end
    in_valid_i <= 1'b0;

    wait_drained();
    repeat (20) @(posedge clk_i);
    mismatches += pending_results.size();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Result side: one long hold-off lets the block fill up and stall its input.
  initial begin : result_side
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        results_seen++;
        check_result(out_data_o);
        stall_left = (results_seen == LONG_HOLD_AT) ? LONG_HOLD
                                                    : draw_wait(recv_run, recv_calm);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left > 0);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: text_terminal_cursor_scroll_top.f
rtl/ttcs_pkg.sv
rtl/ttcs_ram.sv
rtl/ttcs_outreg.sv
rtl/ttcs_ctrl.sv
rtl/text_terminal_cursor_scroll_top.sv
rtl/ttcs_checker.sv
verif/text_terminal_cursor_scroll_top_test.sv
